// File: rtl/core/bcpf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcpf_pkg
// Shared types, codes and the crc-16/xmodem byte update for the packet framer.
// ----------------------------------------------------------------------------
package bcpf_pkg;

    typedef enum logic [1:0] {
        ACT_START = 2'd0,
        ACT_DATA  = 2'd1,
        ACT_CLOSE = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    localparam logic [15:0] CRC_POLY   = 16'h1021;
    localparam logic [7:0]  HDR_SYNC0  = 8'hFE;
    localparam logic [7:0]  HDR_SYNC1  = 8'h00;
    localparam logic [7:0]  HDR_SYNC2  = 8'hFF;
    localparam logic [7:0]  DATA_TAG   = 8'hDA;
    localparam logic [7:0]  CLOSE_TAG  = 8'hED;
    localparam logic [7:0]  COUNT_INIT = 8'h01;

    // byte positions inside a packet sequence
    localparam logic [3:0] POS_HDR_CRC_HI  = 4'd12;
    localparam logic [3:0] POS_HDR_CRC_LO  = 4'd13;
    localparam logic [3:0] POS_DATA_PAY    = 4'd3;
    localparam logic [3:0] POS_DATA_CRC_HI = 4'd4;
    localparam logic [3:0] POS_DATA_CRC_LO = 4'd5;
    localparam logic [3:0] POS_CLS_CRC_HI  = 4'd3;
    localparam logic [3:0] POS_CLS_CRC_LO  = 4'd4;

    typedef struct packed {
        action_t     kind;
        logic        open;
        logic        last;
        logic [7:0]  count;
        logic [7:0]  data;
        logic [31:0] size;
        logic [31:0] addr;
        logic [7:0]  mode;
    } cmd_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// File: rtl/core/bcpf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcpf_front
// Accepts items, tracks packet state and turns each item with a used action code into a command.
// ----------------------------------------------------------------------------
module bcpf_front import bcpf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  action,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    input  logic [31:0] comp_size,
    input  logic [31:0] load_addr,
    input  logic [7:0]  load_mode,
    output logic        push,
    output cmd_t        push_cmd,
    input  logic        q_ready
);

    logic       in_packet_reg, in_packet_next;
    logic [7:0] count_reg, count_next;
    logic       accept;
    action_t    act;

    assign act      = action_t'(action);
    assign in_ready = q_ready;
    assign accept   = in_valid && q_ready;
    // unused action code is taken and dropped
    assign push     = accept && (act != ACT_NONE);

    always_comb
    begin
        push_cmd.kind  = act;
        push_cmd.open  = !in_packet_reg;
        push_cmd.last  = last_byte;
        push_cmd.count = count_reg;
        push_cmd.data  = data_byte;
        push_cmd.size  = comp_size;
        push_cmd.addr  = load_addr;
        push_cmd.mode  = load_mode;
        in_packet_next = in_packet_reg;
        count_next     = count_reg;
        case (act)
            ACT_START:
            begin
                in_packet_next = 1'b0;
                count_next     = COUNT_INIT;
            end
            ACT_DATA:
            begin
                if (last_byte)
                begin
                    in_packet_next = 1'b0;
                    count_next     = count_reg + 8'd1;
                end
                else
                begin
                    in_packet_next = 1'b1;
                end
            end
            ACT_CLOSE:
            begin
                in_packet_next = 1'b0;
            end
            default:
            begin
                in_packet_next = in_packet_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_packet_reg <= 1'b0;
            count_reg     <= COUNT_INIT;
        end
        else if (push)
        begin
            in_packet_reg <= in_packet_next;
            count_reg     <= count_next;
        end
    end

endmodule

// File: rtl/core/bcpf_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcpf_queue
// Two-entry command queue between the front and back parts.
// ----------------------------------------------------------------------------
module bcpf_queue import bcpf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic q_ready,
    output logic head_valid,
    output cmd_t head_cmd,
    input  logic pop
);

    cmd_t       mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;

    assign q_ready    = (fill_reg != 2'd2);
    assign head_valid = (fill_reg != 2'd0);
    assign head_cmd   = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)
                fill_reg <= fill_reg + 2'd1;
            else if (pop && !push)
                fill_reg <= fill_reg - 2'd1;
        end
    end

endmodule

// File: rtl/core/bcpf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcpf_back
// Expands each command into packet bytes, folds the crc, drives the output.
// ----------------------------------------------------------------------------
module bcpf_back import bcpf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       head_valid,
    input  cmd_t       head_cmd,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       frame_end,
    output logic       last
);

    logic        first_reg;
    logic [3:0]  pos_reg;
    logic [15:0] crc_reg;
    logic        ov_reg;
    logic [7:0]  byte_reg;
    logic        fe_reg;
    logic        last_reg;

    logic [3:0]  pos;
    logic [15:0] crc_cur;
    logic [7:0]  byte_val;
    logic        is_crc;
    logic        is_lo;
    logic        is_final;
    logic        fire;

    assign fire = head_valid && (!ov_reg || out_ready);
    assign pop  = fire && is_final;

    always_comb
    begin
        // continuing data packet keeps its running crc, everything else starts at zero
        pos     = pos_reg;
        crc_cur = crc_reg;
        if (first_reg)
        begin
            if (head_cmd.kind == ACT_DATA && !head_cmd.open)
                pos = POS_DATA_PAY;
            else
            begin
                pos     = 4'd0;
                crc_cur = 16'h0000;
            end
        end
        byte_val = crc_cur[15:8];
        is_crc   = 1'b0;
        is_lo    = 1'b0;
        is_final = 1'b0;
        case (head_cmd.kind)
            ACT_START:
            begin
                case (pos)
                    4'd0:  byte_val = HDR_SYNC0;
                    4'd1:  byte_val = HDR_SYNC1;
                    4'd2:  byte_val = HDR_SYNC2;
                    4'd3:  byte_val = head_cmd.mode;
                    4'd4:  byte_val = head_cmd.size[31:24];
                    4'd5:  byte_val = head_cmd.size[23:16];
                    4'd6:  byte_val = head_cmd.size[15:8];
                    4'd7:  byte_val = head_cmd.size[7:0];
                    4'd8:  byte_val = head_cmd.addr[31:24];
                    4'd9:  byte_val = head_cmd.addr[23:16];
                    4'd10: byte_val = head_cmd.addr[15:8];
                    4'd11: byte_val = head_cmd.addr[7:0];
                    default:
                    begin
                        is_crc   = 1'b1;
                        is_lo    = (pos == POS_HDR_CRC_LO);
                        is_final = is_lo;
                        byte_val = is_lo ? crc_cur[7:0] : crc_cur[15:8];
                    end
                endcase
            end
            ACT_DATA:
            begin
                case (pos)
                    4'd0: byte_val = DATA_TAG;
                    4'd1: byte_val = head_cmd.count;
                    4'd2: byte_val = ~head_cmd.count;
                    4'd3:
                    begin
                        byte_val = head_cmd.data;
                        is_final = !head_cmd.last;
                    end
                    default:
                    begin
                        is_crc   = 1'b1;
                        is_lo    = (pos == POS_DATA_CRC_LO);
                        is_final = is_lo;
                        byte_val = is_lo ? crc_cur[7:0] : crc_cur[15:8];
                    end
                endcase
            end
            default:
            begin
                // close packet
                case (pos)
                    4'd0: byte_val = CLOSE_TAG;
                    4'd1: byte_val = head_cmd.count;
                    4'd2: byte_val = ~head_cmd.count;
                    default:
                    begin
                        is_crc   = 1'b1;
                        is_lo    = (pos == POS_CLS_CRC_LO);
                        is_final = is_lo;
                        byte_val = is_lo ? crc_cur[7:0] : crc_cur[15:8];
                    end
                endcase
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            byte_reg <= byte_val;
            fe_reg   <= is_lo;
            last_reg <= is_final;
            crc_reg  <= is_crc ? crc_cur : crc_byte(crc_cur, byte_val);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg <= 1'b1;
            pos_reg   <= 4'd0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                ov_reg <= 1'b1;
                if (is_final)
                    first_reg <= 1'b1;
                else
                begin
                    first_reg <= 1'b0;
                    pos_reg   <= pos + 4'd1;
                end
            end
            else if (out_ready)
                ov_reg <= 1'b0;
        end
    end

    assign out_valid = ov_reg;
    assign out_byte  = byte_reg;
    assign frame_end = fe_reg;
    assign last      = last_reg;

endmodule

// File: rtl/core/boot_command_packet_framer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// boot_command_packet_framer
// Frames start, payload and close commands into a byte stream of packets,
// each closed by a crc-16/xmodem sent high byte first.
// ----------------------------------------------------------------------------
//  channel  handshake             payload
//  in       in_valid / in_ready   action, data_byte, last_byte, comp_size,
//                                 load_addr, load_mode
//  out      out_valid / out_ready out_byte, frame_end, last
//
// one output byte per cycle while out_ready is high; bytes per item:
// start 14, close 5, payload 1 to 6 (header and crc bytes add to the payload)
// the back sequencer and its output register set this rate; a plain payload
// byte passes one per cycle; the first passes the queue, then the output register
// reset clears packet state (counter to 1, no open packet) and the queue
// a two-entry queue lets the front accept up to two commands while the back stalls
// ----------------------------------------------------------------------------
module boot_command_packet_framer import bcpf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  action,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    input  logic [31:0] comp_size,
    input  logic [31:0] load_addr,
    input  logic [7:0]  load_mode,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        frame_end,
    output logic        last
);

    // front to queue
    logic push;
    cmd_t push_cmd;
    logic q_ready;

    // queue to back
    logic head_valid;
    cmd_t head_cmd;
    logic pop;

    // classify items and keep packet counter / open-packet state
    bcpf_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .action    (action),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .comp_size (comp_size),
        .load_addr (load_addr),
        .load_mode (load_mode),
        .push      (push),
        .push_cmd  (push_cmd),
        .q_ready   (q_ready)
    );

    // decouples acceptance from byte emission
    bcpf_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .q_ready    (q_ready),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop)
    );

    // byte sequencer with running crc and registered output
    bcpf_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .frame_end  (frame_end),
        .last       (last)
    );

endmodule
